>>> src/bgc_pkg.sv
// Package for the button gesture classifier.
// Holds the mode type, the event and gesture codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package bgc_pkg;

    localparam int TICKS_W     = 16;
    localparam int GESTURE_W   = 2;
    localparam int KEY_VALUE_W = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef logic [TICKS_W-1:0]     ticks_t;
    typedef logic [GESTURE_W-1:0]   gesture_t;
    typedef logic [KEY_VALUE_W-1:0] key_value_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    typedef enum logic [1:0] {
        MODE_IDLE          = 2'd0,
        MODE_FIRST_PRESS   = 2'd1,
        MODE_FIRST_RELEASE = 2'd2
    } mode_t;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    localparam key_value_t KEY_RELEASE = 2'd0;
    localparam key_value_t KEY_PRESS   = 2'd1;

    localparam gesture_t GESTURE_SINGLE = 2'd0;
    localparam gesture_t GESTURE_DOUBLE = 2'd1;
    localparam gesture_t GESTURE_LONG   = 2'd2;

    localparam cfg_index_t REG_LONG_PRESS_MS   = 2'd0;
    localparam cfg_index_t REG_DOUBLE_CLICK_MS = 2'd1;

    localparam ticks_t LONG_PRESS_RESET   = 16'd300;
    localparam ticks_t DOUBLE_CLICK_RESET = 16'd300;
    localparam ticks_t TICKS_MAX          = 16'hFFFF;

endpackage

`default_nettype wire

>>> src/bgc_if.sv
// Channel interfaces of the button gesture classifier: input words, result words
// and configuration writes, each with valid/ready. Depends on bgc_pkg.
`default_nettype none

interface bgc_item_if;
    logic                  valid;
    logic                  ready;
    logic                  cmd;
    logic                  event_is_key;
    bgc_pkg::key_value_t   key_value;

    modport source (output valid, output cmd, output event_is_key, output key_value,
                    input ready);
    modport sink   (input valid, input cmd, input event_is_key, input key_value,
                    output ready);
endinterface

interface bgc_result_if;
    logic                valid;
    logic                ready;
    bgc_pkg::gesture_t   gesture;

    modport source (output valid, output gesture, input ready);
    modport sink   (input valid, input gesture, output ready);
endinterface

interface bgc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    bgc_pkg::cfg_index_t                  index;
    logic [bgc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/button_gesture_classifier.sv
// Top level of the button gesture classifier: input register, mode/counter update
// and result register. Depends on bgc_pkg and the interfaces in bgc_if.sv.
`default_nettype none

// Classify one push button into single click, double click and long press.
//
// item_in    : one word per millisecond tick (cmd = 0) or input event (cmd = 1).
//              Non-key events, autorepeat and unknown key values change nothing.
// result_out : one gesture word (0 single, 1 double, 2 long) for the input
//              words that complete a gesture; all others produce no word.
// cfg        : register writes, index 0 = long_press_ms, 1 = double_click_window_ms.
//              Always ready; writes to other indexes are dropped.
//
// Timing: a word lands in the input register; when it advances, mode and
// counter update and the result register loads, so a gesture appears on
// result_out once its input word leaves the input register. One word per
// cycle is sustained unless a result waits; the only loop is the mode/counter update.
// Stall: while a result waits on result_out, the input register still drains
// into the result stage once the receiver takes the held word; item_in ready
// follows that same advance, so nothing is lost or repeated.
// Reset: mode idle, counter zero, both windows 300 ticks, no word held.

module button_gesture_classifier (
    input  wire logic           clk,
    input  wire logic           rst_n,
    bgc_item_if.sink            item_in,
    bgc_result_if.source        result_out,
    bgc_cfg_if.sink             cfg
);

    // Configuration
    bgc_pkg::ticks_t long_press_reg;
    bgc_pkg::ticks_t window_reg;

    // Input register
    logic                 in_valid_reg;
    logic                 in_cmd_reg;
    logic                 in_is_key_reg;
    bgc_pkg::key_value_t  in_key_reg;

    // Classifier state
    bgc_pkg::mode_t   mode_reg, mode_next;
    bgc_pkg::ticks_t  elapsed_reg, elapsed_next;

    // Result register
    logic               out_valid_reg;
    bgc_pkg::gesture_t  out_gesture_reg;

    logic               advance;
    logic               hit;
    bgc_pkg::gesture_t  gesture_next;
    bgc_pkg::ticks_t    elapsed_inc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg <= bgc_pkg::LONG_PRESS_RESET;
            window_reg     <= bgc_pkg::DOUBLE_CLICK_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bgc_pkg::REG_LONG_PRESS_MS:   long_press_reg <= cfg.data;
                bgc_pkg::REG_DOUBLE_CLICK_MS: window_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    // Move the held word on when the result slot is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign item_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.ready && item_in.valid)
        begin
            in_cmd_reg    <= item_in.cmd;
            in_is_key_reg <= item_in.event_is_key;
            in_key_reg    <= item_in.key_value;
        end
    end

    // Saturating millisecond counter
    assign elapsed_inc = (elapsed_reg == bgc_pkg::TICKS_MAX) ? elapsed_reg
                                                            : elapsed_reg + 16'd1;

    always_comb
    begin
        mode_next    = mode_reg;
        elapsed_next = elapsed_reg;
        hit          = 1'b0;
        gesture_next = bgc_pkg::GESTURE_SINGLE;
        if (in_cmd_reg == bgc_pkg::CMD_TICK)
        begin
            case (mode_reg)
                bgc_pkg::MODE_FIRST_PRESS:
                begin
                    elapsed_next = elapsed_inc;
                end
                bgc_pkg::MODE_FIRST_RELEASE:
                begin
                    elapsed_next = elapsed_inc;
                    // Window ran out: single click
                    if (elapsed_inc >= window_reg)
                    begin
                        mode_next    = bgc_pkg::MODE_IDLE;
                        hit          = 1'b1;
                        gesture_next = bgc_pkg::GESTURE_SINGLE;
                    end
                end
                default: ;
            endcase
        end
        else if (in_is_key_reg)
        begin
            if (in_key_reg == bgc_pkg::KEY_PRESS)
            begin
                case (mode_reg)
                    bgc_pkg::MODE_FIRST_PRESS: ;
                    bgc_pkg::MODE_FIRST_RELEASE:
                    begin
                        mode_next    = bgc_pkg::MODE_IDLE;
                        hit          = 1'b1;
                        gesture_next = bgc_pkg::GESTURE_DOUBLE;
                    end
                    default:
                    begin
                        mode_next    = bgc_pkg::MODE_FIRST_PRESS;
                        elapsed_next = '0;
                    end
                endcase
            end
            else if (in_key_reg == bgc_pkg::KEY_RELEASE)
            begin
                if (mode_reg == bgc_pkg::MODE_FIRST_PRESS)
                begin
                    if (elapsed_reg > long_press_reg)
                    begin
                        mode_next    = bgc_pkg::MODE_IDLE;
                        hit          = 1'b1;
                        gesture_next = bgc_pkg::GESTURE_LONG;
                    end
                    else
                    begin
                        // Short hold: open the double-click window
                        mode_next    = bgc_pkg::MODE_FIRST_RELEASE;
                        elapsed_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= bgc_pkg::MODE_IDLE;
            elapsed_reg <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= hit;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit)
        begin
            out_gesture_reg <= gesture_next;
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.gesture = out_gesture_reg;

endmodule

`default_nettype wire
